@@ hdl/signed_seven_segment_formatter_macros.svh @@
// assertion helpers for the checker file
`ifndef SIGNED_SEVEN_SEGMENT_FORMATTER_MACROS_SVH
`define SIGNED_SEVEN_SEGMENT_FORMATTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssf check failed");

// next-cycle implication, disabled while reset is asserted
`define SSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssf check failed");

`endif

@@ hdl/ssf_pkg.sv @@
`default_nettype none
package ssf_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned PointW   = 4;
  localparam int unsigned SegW     = 8;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned BcdW     = 4 * NumDigits;
  localparam int unsigned CntW     = $clog2(ValueW);

  localparam logic [CntW-1:0] LastBit  = CntW'(ValueW - 1);

  localparam logic [SegW-1:0] SegBlank = 8'h00;
  localparam logic [SegW-1:0] SegMinus = 8'h20;
  localparam logic [SegW-1:0] PointMaskReset = 8'h04;

  // converter sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } conv_state_e;

  // converter result handed to the encoder
  typedef struct packed {
    logic                   neg;
    logic [PointW-1:0]      point_position;
    logic [BcdW-1:0]        bcd;
    logic                   ovf;
  } conv_res_t;

  // six segment bytes of one result
  typedef struct packed {
    logic [SegW-1:0] sign;
    logic [SegW-1:0] ten_thousands;
    logic [SegW-1:0] thousands;
    logic [SegW-1:0] hundreds;
    logic [SegW-1:0] tens;
    logic [SegW-1:0] units;
  } seg_res_t;

  // segment pattern of one decimal digit
  function automatic logic [SegW-1:0] digit_seg(input logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 8'hDB;
      4'd1:    s = 8'h11;
      4'd2:    s = 8'hBA;
      4'd3:    s = 8'hB3;
      4'd4:    s = 8'h71;
      4'd5:    s = 8'hE3;
      4'd6:    s = 8'hEB;
      4'd7:    s = 8'h91;
      4'd8:    s = 8'hFB;
      4'd9:    s = 8'hF3;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ssf_in_if.sv @@
`default_nettype none
interface ssf_in_if
  import ssf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic signed [PointW-1:0] point_position;

  modport source (output valid, output value, output point_position, input ready);
  modport sink   (input valid, input value, input point_position, output ready);
endinterface
`default_nettype wire

@@ hdl/ssf_out_if.sv @@
`default_nettype none
interface ssf_out_if
  import ssf_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [SegW-1:0] seg_sign;
  logic [SegW-1:0] seg_ten_thousands;
  logic [SegW-1:0] seg_thousands;
  logic [SegW-1:0] seg_hundreds;
  logic [SegW-1:0] seg_tens;
  logic [SegW-1:0] seg_units;

  modport source (output valid, output seg_sign, output seg_ten_thousands,
                  output seg_thousands, output seg_hundreds, output seg_tens,
                  output seg_units, input ready);
  modport sink   (input valid, input seg_sign, input seg_ten_thousands,
                  input seg_thousands, input seg_hundreds, input seg_tens,
                  input seg_units, output ready);
endinterface
`default_nettype wire

@@ hdl/ssf_dabble.sv @@
`default_nettype none
module ssf_dabble
  import ssf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic signed [PointW-1:0] point_position_i,
  input  wire logic                     ack_i,
  output logic                          idle_o,
  output logic                          done_o,
  output conv_res_t                     res_o
);

  conv_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              ovf_q, ovf_d;
  logic              neg_q, neg_d;
  logic [PointW-1:0] pp_q, pp_d;
  logic [BcdW-1:0]   bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  // sequencer: load, shift one bit per cycle, hold until taken
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    pp_d    = pp_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[ValueW-1];
          mag_d   = value_i[ValueW-1] ? (ValueW'(0) - ValueW'(value_i)) : ValueW'(value_i);
          pp_d    = PointW'(point_position_i);
          bcd_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
        ovf_d = ovf_q | bcd_adj[BcdW-1];
        mag_d = {mag_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastBit) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
    pp_q  <= pp_d;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign res_o  = '{neg: neg_q, point_position: pp_q, bcd: bcd_q, ovf: ovf_q};

endmodule
`default_nettype wire

@@ hdl/ssf_encode.sv @@
`default_nettype none
module ssf_encode
  import ssf_pkg::*;
(
  input  wire conv_res_t        res_i,
  input  wire logic [SegW-1:0]  dp_mask_i,
  output seg_res_t              seg_o
);

  logic [NumDigits-1:0] lit;
  logic [SegW-1:0]      dig_seg [NumDigits];

  // a digit is lit if it or any higher digit (shown or dropped) is nonzero; the units digit is always lit
  always_comb begin
    lit[NumDigits-1] = res_i.ovf | (res_i.bcd[BcdW-1 -: 4] != 4'd0);
    for (int k = NumDigits - 2; k >= 1; k--) begin
      lit[k] = lit[k+1] | (res_i.bcd[4*k +: 4] != 4'd0);
    end
    lit[0] = 1'b1;
  end

  // pattern lookup, blanking and the point
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      dig_seg[k] = lit[k] ? digit_seg(res_i.bcd[4*k +: 4]) : SegBlank;
      if (res_i.point_position == PointW'(k + 1)) begin
        dig_seg[k] = dig_seg[k] | dp_mask_i;
      end
    end
  end

  assign seg_o = '{sign:          (res_i.neg ? SegMinus : SegBlank),
                   ten_thousands: dig_seg[4],
                   thousands:     dig_seg[3],
                   hundreds:      dig_seg[2],
                   tens:          dig_seg[1],
                   units:         dig_seg[0]};

endmodule
`default_nettype wire

@@ hdl/signed_seven_segment_formatter.sv @@
// channel | dir | handshake     | payload
// in_i    | in  | valid/ready   | value (s32), point_position (s4)
// out_o   | out | valid/ready   | seg_sign .. seg_units (six u8)
// cfg     | in  | cfg_we_i      | cfg_wdata_i -> point_segment_mask
//
// an accepted transaction passes through one load, 32 shift-and-adjust steps
// of the bit-serial binary-to-decimal converter and one hand-off to the output register
// a new transaction is accepted while the previous result waits on out_o
// rst_ni clears the converter, the output valid and sets point_segment_mask to 0x04
// a stalled out_o holds its result; the converter then waits in its done state
`default_nettype none
module signed_seven_segment_formatter
  import ssf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [SegW-1:0] cfg_wdata_i,
  ssf_in_if.sink               in_i,
  ssf_out_if.source            out_o
);

  logic            conv_idle;
  logic            conv_done;
  logic            conv_ack;
  conv_res_t       conv_res;
  seg_res_t        seg_res;
  seg_res_t        out_q;
  logic            out_valid_q;
  logic [SegW-1:0] dp_mask_q;

  // point segment mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_mask_q <= PointMaskReset;
    end else if (cfg_we_i) begin
      dp_mask_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = conv_idle;

  ssf_dabble u_dabble (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (in_i.valid & conv_idle),
    .value_i          (in_i.value),
    .point_position_i (in_i.point_position),
    .ack_i            (conv_ack),
    .idle_o           (conv_idle),
    .done_o           (conv_done),
    .res_o            (conv_res)
  );

  ssf_encode u_encode (
    .res_i     (conv_res),
    .dp_mask_i (dp_mask_q),
    .seg_o     (seg_res)
  );

  // hand the finished conversion to the output register when it is free
  assign conv_ack = conv_done & (~out_valid_q | out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (conv_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_ack) begin
      out_q <= seg_res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.seg_sign          = out_q.sign;
  assign out_o.seg_ten_thousands = out_q.ten_thousands;
  assign out_o.seg_thousands     = out_q.thousands;
  assign out_o.seg_hundreds      = out_q.hundreds;
  assign out_o.seg_tens          = out_q.tens;
  assign out_o.seg_units         = out_q.units;

endmodule
`default_nettype wire

@@ hdl/ssf_checker.sv @@
`default_nettype none
`include "signed_seven_segment_formatter_macros.svh"
module ssf_checker
  import ssf_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [SegW-1:0] seg_sign_i,
  input wire logic [SegW-1:0] seg_units_i
);

  // a held result stays offered
  `SSF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // the converter is busy right after taking a transaction
  `SSF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // the units digit is always lit
  `SSF_ASSERT_IMP(a_units_lit, clk_i, rst_ni, out_valid_i, seg_units_i != SegBlank)

  // the sign position is only ever blank or minus
  `SSF_ASSERT_IMP(a_sign_code, clk_i, rst_ni, out_valid_i,
                  seg_sign_i == SegBlank || seg_sign_i == SegMinus)

endmodule

bind signed_seven_segment_formatter ssf_checker u_ssf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .seg_sign_i  (out_o.seg_sign),
  .seg_units_i (out_o.seg_units)
);
`default_nettype wire
